>>> sv/fbm_pkg.sv
// ----------------------------------------------------------------------------
// fbm_pkg
// Shared constants, types and lattice helper functions for the fBm noise block.
// ----------------------------------------------------------------------------
package fbm_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int CELL_MASK_DEF   = 255;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LACUNARITY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SCALE   = 3'd4;

    localparam logic [31:0] HASH_SALT = 32'd61;
    localparam logic [31:0] HASH_MASK = 32'h7fff_ffff;
    localparam logic [16:0] AMP_ONE   = 17'd65536;
    localparam logic [17:0] FADE_K3   = 18'd196608;

    typedef struct packed {
        logic        first;
        logic        last;
        logic        zero;
        logic [16:0] amp;
    } ctl_t;

    function automatic logic [31:0] asr4(input logic [31:0] h);
        return {{4{h[31]}}, h[31:4]};
    endfunction

    function automatic logic [31:0] hash_x(input logic [31:0] seed, input logic [31:0] x);
        logic [31:0] h;
        h = seed ^ (HASH_SALT ^ x);
        h = h + (h << 3);
        h = h ^ asr4(h);
        return h;
    endfunction

    function automatic logic [31:0] hash_yz(input logic [31:0] h, input logic [31:0] v);
        return h + ((h << 3) ^ v);
    endfunction

    function automatic logic [31:0] hash_fin(input logic [31:0] hin);
        logic [31:0] h;
        h = hin ^ asr4(hin);
        h = h + (h << 3);
        return h & HASH_MASK;
    endfunction

    function automatic logic signed [19:0] gradient(input logic [3:0] sel,
                                                   input logic signed [17:0] dx,
                                                   input logic signed [17:0] dy,
                                                   input logic signed [17:0] dz);
        logic signed [19:0] a;
        logic signed [19:0] b;
        a = sel[3] ? 20'(dy) : 20'(dx);
        b = sel[3] ? 20'(dz) : 20'(dy);
        if (sel[0])
        begin
            a = -a;
        end
        if (sel[1])
        begin
            b = -b;
        end
        return a + b;
    endfunction

    function automatic logic signed [19:0] blend(input logic signed [19:0] a,
                                                input logic signed [19:0] b,
                                                input logic [16:0] f);
        logic signed [20:0] d;
        logic signed [38:0] p;
        logic signed [38:0] s;
        d = 21'(b) - 21'(a);
        p = 39'(d) * 39'($signed({1'b0, f}));
        s = p >>> 16;
        return a + 20'(s);
    endfunction

endpackage

>>> sv/fbm_gradient_noise_3d.sv
// ----------------------------------------------------------------------------
// fbm_gradient_noise_3d
// Fractal Brownian motion of 3D hash-gradient noise; one octave core reused
// per octave, followed by a weighted accumulator and a pipelined divider.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// in        in   in_valid / in_stall    pos_x, pos_y, pos_z
// out       out  out_valid / out_stall  noise_value
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each word is issued as max(1, octaves) octaves (capped at MAX_OCTAVES):
// the octave issuer feeds one octave per cycle, unless the pipe is frozen,
// into a 9-stage octave core. Reset clears control and restores the register
// defaults. out_stall only freezes the pipe when a finished word waits in the
// output register and another sits in the last stage.
// ----------------------------------------------------------------------------
module fbm_gradient_noise_3d #(
    parameter int MAX_OCTAVES = fbm_pkg::MAX_OCTAVES_DEF,
    parameter int CELL_MASK   = fbm_pkg::CELL_MASK_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [31:0]             pos_x,
    input  logic signed [31:0]             pos_y,
    input  logic signed [31:0]             pos_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [17:0]             noise_value,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);

    localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
    localparam int CELL_W = $clog2(CELL_MASK + 1);
    localparam int SUM_W  = 37 + OCT_W;
    localparam int WSUM_W = 17 + OCT_W;
    localparam int QW     = 19;
    localparam int CW     = SUM_W + QW;
    localparam logic [CELL_W-1:0] CMASK = CELL_W'(CELL_MASK);

    // configuration
    logic [31:0] seed_reg;
    logic [3:0]  octave_count_reg;
    logic [16:0] persistence_reg;
    logic [15:0] lacunarity_reg;
    logic [23:0] base_scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg         <= '0;
            octave_count_reg <= 4'd4;
            persistence_reg  <= 17'd32768;
            lacunarity_reg   <= 16'd512;
            base_scale_reg   <= 24'd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fbm_pkg::REG_NOISE_SEED:   seed_reg         <= cfg_data;
                fbm_pkg::REG_OCTAVE_COUNT: octave_count_reg <= cfg_data[3:0];
                fbm_pkg::REG_PERSISTENCE:  persistence_reg  <= cfg_data[16:0];
                fbm_pkg::REG_LACUNARITY:   lacunarity_reg   <= cfg_data[15:0];
                fbm_pkg::REG_BASE_SCALE:   base_scale_reg   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic adv;
    logic out_valid_reg;
    logic signed [17:0] noise_reg;
    logic div_v_reg [0:QW];

    assign adv = !(out_valid_reg && out_stall && div_v_reg[QW]);

    // octave issuer
    logic              busy_reg;
    logic              zero_reg;
    logic [OCT_W-1:0]  oct_reg;
    logic [OCT_W-1:0]  n_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [31:0]       freq_reg;
    logic [16:0]       amp_reg;
    logic              last_emit;
    logic              accept;
    logic [OCT_W-1:0]  n_clamp;
    logic [16:0]       pers_c;
    logic [47:0]       freq_prod;
    logic [31:0]       freq_next;
    logic [33:0]       amp_prod;
    logic [16:0]       amp_next;

    always_comb
    begin
        if (32'(octave_count_reg) > 32'(MAX_OCTAVES))
        begin
            n_clamp = OCT_W'(MAX_OCTAVES);
        end
        else
        begin
            n_clamp = OCT_W'(octave_count_reg);
        end
        pers_c    = (persistence_reg > fbm_pkg::AMP_ONE) ? fbm_pkg::AMP_ONE : persistence_reg;
        freq_prod = 48'(freq_reg) * 48'(lacunarity_reg);
        freq_next = (|freq_prod[47:40]) ? 32'hffff_ffff : freq_prod[39:8];
        amp_prod  = 34'(amp_reg) * 34'(pers_c);
        amp_next  = amp_prod[32:16];
    end

    assign last_emit = busy_reg && (zero_reg || (oct_reg == n_reg - OCT_W'(1)));
    assign in_stall  = !adv || (busy_reg && !last_emit);
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (adv && last_emit)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            pz_reg   <= pos_z;
            n_reg    <= n_clamp;
            zero_reg <= (n_clamp == '0);
            oct_reg  <= '0;
            freq_reg <= 32'(base_scale_reg);
            amp_reg  <= fbm_pkg::AMP_ONE;
        end
        else if (adv && busy_reg)
        begin
            oct_reg  <= oct_reg + OCT_W'(1);
            freq_reg <= freq_next;
            amp_reg  <= amp_next;
        end
    end

    // S1: position scaling
    logic signed [64:0] prx, pry, prz;
    logic [CELL_W-1:0]  s1_cell_reg [0:2];
    logic [15:0]        s1_frac_reg [0:2];
    logic [31:0]        s1_seed_reg;
    fbm_pkg::ctl_t      s1_ctl_reg;
    logic               s1_v_reg;

    assign prx = 65'(px_reg) * $signed({33'd0, freq_reg});
    assign pry = 65'(py_reg) * $signed({33'd0, freq_reg});
    assign prz = 65'(pz_reg) * $signed({33'd0, freq_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cell_reg[0] <= prx[32+CELL_W-1:32] & CMASK;
            s1_cell_reg[1] <= pry[32+CELL_W-1:32] & CMASK;
            s1_cell_reg[2] <= prz[32+CELL_W-1:32] & CMASK;
            s1_frac_reg[0] <= prx[31:16];
            s1_frac_reg[1] <= pry[31:16];
            s1_frac_reg[2] <= prz[31:16];
            s1_seed_reg    <= seed_reg + 32'(oct_reg);
            s1_ctl_reg     <= '{first: (oct_reg == '0), last: last_emit,
                                zero: zero_reg, amp: amp_reg};
        end
    end

    // S2: x hash, t squared
    logic [31:0]   s2_hx_reg [0:1];
    logic [31:0]   s2_cy_reg [0:1];
    logic [31:0]   s2_cz_reg [0:1];
    logic [15:0]   s2_frac_reg [0:2];
    logic [15:0]   s2_tt_reg [0:2];
    fbm_pkg::ctl_t s2_ctl_reg;
    logic          s2_v_reg;
    logic [CELL_W-1:0] cx1, cy1, cz1;
    logic [31:0]   tsq [0:2];

    always_comb
    begin
        cx1 = (s1_cell_reg[0] + CELL_W'(1)) & CMASK;
        cy1 = (s1_cell_reg[1] + CELL_W'(1)) & CMASK;
        cz1 = (s1_cell_reg[2] + CELL_W'(1)) & CMASK;
        for (int a = 0; a < 3; a++)
        begin
            tsq[a] = 32'(s1_frac_reg[a]) * 32'(s1_frac_reg[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_hx_reg[0] <= fbm_pkg::hash_x(s1_seed_reg, 32'(s1_cell_reg[0]));
            s2_hx_reg[1] <= fbm_pkg::hash_x(s1_seed_reg, 32'(cx1));
            s2_cy_reg[0] <= 32'(s1_cell_reg[1]);
            s2_cy_reg[1] <= 32'(cy1);
            s2_cz_reg[0] <= 32'(s1_cell_reg[2]);
            s2_cz_reg[1] <= 32'(cz1);
            for (int a = 0; a < 3; a++)
            begin
                s2_frac_reg[a] <= s1_frac_reg[a];
                s2_tt_reg[a]   <= tsq[a][31:16];
            end
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // S3: y hash, fade
    logic [31:0]   s3_hy_reg [0:3];
    logic [31:0]   s3_cz_reg [0:1];
    logic [15:0]   s3_frac_reg [0:2];
    logic [16:0]   s3_fade_reg [0:2];
    fbm_pkg::ctl_t s3_ctl_reg;
    logic          s3_v_reg;
    logic [33:0]   fprod [0:2];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            fprod[a] = 34'(s2_tt_reg[a]) *
                       34'(fbm_pkg::FADE_K3 - {1'b0, s2_frac_reg[a], 1'b0});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s3_hy_reg[k] <= fbm_pkg::hash_yz(s2_hx_reg[k % 2], s2_cy_reg[k / 2]);
            end
            s3_cz_reg[0] <= s2_cz_reg[0];
            s3_cz_reg[1] <= s2_cz_reg[1];
            for (int a = 0; a < 3; a++)
            begin
                s3_frac_reg[a] <= s2_frac_reg[a];
                s3_fade_reg[a] <= fprod[a][32:16];
            end
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    // S4: z hash
    logic [31:0]   s4_hz_reg [0:7];
    logic [15:0]   s4_frac_reg [0:2];
    logic [16:0]   s4_fade_reg [0:2];
    fbm_pkg::ctl_t s4_ctl_reg;
    logic          s4_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 8; k++)
            begin
                s4_hz_reg[k] <= fbm_pkg::hash_yz(s3_hy_reg[k % 4], s3_cz_reg[k / 4]);
            end
            for (int a = 0; a < 3; a++)
            begin
                s4_frac_reg[a] <= s3_frac_reg[a];
                s4_fade_reg[a] <= s3_fade_reg[a];
            end
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    // S5: hash finish and gradients
    logic signed [19:0] s5_g_reg [0:7];
    logic [16:0]        s5_fade_reg [0:2];
    fbm_pkg::ctl_t      s5_ctl_reg;
    logic               s5_v_reg;
    logic signed [17:0] d0 [0:2];
    logic signed [17:0] d1 [0:2];
    logic [31:0]        hf [0:7];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            d0[a] = $signed({2'b00, s4_frac_reg[a]});
            d1[a] = $signed({2'b00, s4_frac_reg[a]}) - 18'sd65536;
        end
        for (int k = 0; k < 8; k++)
        begin
            hf[k] = fbm_pkg::hash_fin(s4_hz_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 8; k++)
            begin
                s5_g_reg[k] <= fbm_pkg::gradient(hf[k][3:0],
                                                 k[0] ? d1[0] : d0[0],
                                                 k[1] ? d1[1] : d0[1],
                                                 k[2] ? d1[2] : d0[2]);
            end
            for (int a = 0; a < 3; a++)
            begin
                s5_fade_reg[a] <= s4_fade_reg[a];
            end
            s5_ctl_reg <= s4_ctl_reg;
        end
    end

    // S6..S8: trilinear blend
    logic signed [19:0] s6_b_reg [0:3];
    logic [16:0]        s6_fv_reg, s6_fw_reg;
    fbm_pkg::ctl_t      s6_ctl_reg;
    logic               s6_v_reg;
    logic signed [19:0] s7_b_reg [0:1];
    logic [16:0]        s7_fw_reg;
    fbm_pkg::ctl_t      s7_ctl_reg;
    logic               s7_v_reg;
    logic signed [19:0] s8_nv_reg;
    fbm_pkg::ctl_t      s8_ctl_reg;
    logic               s8_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int m = 0; m < 4; m++)
            begin
                s6_b_reg[m] <= fbm_pkg::blend(s5_g_reg[2*m], s5_g_reg[2*m+1], s5_fade_reg[0]);
            end
            s6_fv_reg  <= s5_fade_reg[1];
            s6_fw_reg  <= s5_fade_reg[2];
            s6_ctl_reg <= s5_ctl_reg;
            s7_b_reg[0] <= fbm_pkg::blend(s6_b_reg[0], s6_b_reg[1], s6_fv_reg);
            s7_b_reg[1] <= fbm_pkg::blend(s6_b_reg[2], s6_b_reg[3], s6_fv_reg);
            s7_fw_reg   <= s6_fw_reg;
            s7_ctl_reg  <= s6_ctl_reg;
            s8_nv_reg   <= fbm_pkg::blend(s7_b_reg[0], s7_b_reg[1], s7_fw_reg);
            s8_ctl_reg  <= s7_ctl_reg;
        end
    end

    // S9: amplitude weighting
    logic signed [36:0] s9_wp_reg;
    fbm_pkg::ctl_t      s9_ctl_reg;
    logic               s9_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_wp_reg  <= 37'(s8_nv_reg) * $signed({20'd0, s8_ctl_reg.amp});
            s9_ctl_reg <= s8_ctl_reg;
        end
    end

    // S10: octave accumulator
    logic signed [SUM_W-1:0] acc_sum_reg;
    logic [WSUM_W-1:0]       acc_wsum_reg;
    logic                    acc_zero_reg;
    logic                    acc_v_reg;
    logic signed [SUM_W-1:0] acc_base;
    logic [WSUM_W-1:0]       wacc_base;

    assign acc_base  = s9_ctl_reg.first ? '0 : acc_sum_reg;
    assign wacc_base = s9_ctl_reg.first ? '0 : acc_wsum_reg;

    always_ff @(posedge clk)
    begin
        if (adv && s9_v_reg)
        begin
            acc_sum_reg  <= acc_base + SUM_W'(s9_wp_reg);
            acc_wsum_reg <= wacc_base + WSUM_W'(s9_ctl_reg.amp);
            acc_zero_reg <= s9_ctl_reg.zero;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            acc_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= busy_reg;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= s5_v_reg;
            s7_v_reg  <= s6_v_reg;
            s8_v_reg  <= s7_v_reg;
            s9_v_reg  <= s8_v_reg;
            acc_v_reg <= s9_v_reg && s9_ctl_reg.last;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [SUM_W-1:0]  div_rem_reg  [0:QW];
    logic [WSUM_W-1:0] div_den_reg  [0:QW];
    logic [QW-1:0]     div_q_reg    [0:QW];
    logic              div_neg_reg  [0:QW];
    logic              div_zero_reg [0:QW];
    logic [CW-1:0]     dshift [0:QW-1];
    logic              dge    [0:QW-1];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            dshift[k] = CW'(div_den_reg[k]) << (QW - 1 - k);
            dge[k]    = CW'(div_rem_reg[k]) >= dshift[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_rem_reg[0]  <= acc_sum_reg[SUM_W-1] ? SUM_W'(-acc_sum_reg) : acc_sum_reg;
            div_den_reg[0]  <= acc_wsum_reg;
            div_q_reg[0]    <= '0;
            div_neg_reg[0]  <= acc_sum_reg[SUM_W-1];
            div_zero_reg[0] <= acc_zero_reg;
            for (int k = 0; k < QW; k++)
            begin
                div_rem_reg[k+1]  <= dge[k] ? SUM_W'(CW'(div_rem_reg[k]) - dshift[k])
                                            : div_rem_reg[k];
                div_den_reg[k+1]  <= div_den_reg[k];
                div_q_reg[k+1]    <= {div_q_reg[k][QW-2:0], dge[k]};
                div_neg_reg[k+1]  <= div_neg_reg[k];
                div_zero_reg[k+1] <= div_zero_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                div_v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            div_v_reg[0] <= acc_v_reg;
            for (int k = 0; k < QW; k++)
            begin
                div_v_reg[k+1] <= div_v_reg[k];
            end
        end
    end

    // sign, saturation, output register
    logic signed [QW:0] qs;
    logic signed [17:0] res_next;

    always_comb
    begin
        qs = $signed({1'b0, div_q_reg[QW]});
        if (div_neg_reg[QW])
        begin
            qs = -qs;
        end
        priority if (div_zero_reg[QW])
        begin
            res_next = '0;
        end
        else if (qs > (QW+1)'(131071))
        begin
            res_next = 18'sd131071;
        end
        else if (qs < -(QW+1)'(131072))
        begin
            res_next = -18'sd131072;
        end
        else
        begin
            res_next = 18'(qs);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= div_v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if ((!out_valid_reg || !out_stall) && div_v_reg[QW])
        begin
            noise_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fbm_gradient_noise_3d. A local fixed-point model of
// the fBm noise predicts each noise_value word; a checker compares the output
// stream in order. Directed corner cases come first, then randomized register
// settings and positions under several input/output idle patterns and one
// long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [fbm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 48;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [31:0]            pos_x = '0;
    logic signed [31:0]            pos_y = '0;
    logic signed [31:0]            pos_z = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [17:0]            noise_value;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [fbm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_data = '0;

    logic [31:0] mdl_seed;
    logic [3:0]  mdl_octaves;
    logic [16:0] mdl_persist;
    logic [15:0] mdl_lacun;
    logic [23:0] mdl_scale;

    logic signed [17:0] expected_noise[$];
    int errors = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    fbm_gradient_noise_3d dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] shr4(input logic [31:0] h);
        return {{4{h[31]}}, h[31:4]};
    endfunction

    function automatic logic [31:0] corner_hash(input logic [31:0] x, input logic [31:0] y,
                                                input logic [31:0] z, input logic [31:0] seed);
        logic [31:0] h;
        h = seed ^ (32'd61 ^ x);
        h = h + (h << 3);
        h = h ^ shr4(h);
        h = h + ((h << 3) ^ y);
        h = h + ((h << 3) ^ z);
        h = h ^ shr4(h);
        h = h + (h << 3);
        return h & 32'h7fff_ffff;
    endfunction

    function automatic longint fade_q16(input logic [15:0] t);
        logic [63:0] t2;
        logic [63:0] k;
        t2 = (64'(t) * 64'(t)) >> 16;
        k = 64'd196608 - 2 * 64'(t);
        return longint'((t2 * k) >> 16);
    endfunction

    function automatic longint mix(input longint a, input longint b, input longint f);
        longint d;
        d = (b - a) * f;
        return a + (d >>> 16);
    endfunction

    function automatic longint octave_value(input logic signed [31:0] px,
                                            input logic signed [31:0] py,
                                            input logic signed [31:0] pz,
                                            input logic [31:0] freq, input logic [31:0] seed);
        logic signed [31:0] p[3];
        logic [63:0] pr;
        logic [31:0] cl[3][2];
        logic [15:0] fr[3];
        longint g[8];
        longint dx, dy, dz, ga, gb, fu, fv, fw, n0, n1;
        logic [3:0] sel;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        for (int a = 0; a < 3; a++)
        begin
            pr = 64'(longint'(p[a])) * {32'd0, freq};
            fr[a] = pr[31:16];
            cl[a][0] = pr[63:32] & 32'd255;
            cl[a][1] = (pr[63:32] + 32'd1) & 32'd255;
        end
        for (int k = 0; k < 8; k++)
        begin
            dx = longint'({48'd0, fr[0]}) - ((k & 1) ? 65536 : 0);
            dy = longint'({48'd0, fr[1]}) - ((k & 2) ? 65536 : 0);
            dz = longint'({48'd0, fr[2]}) - ((k & 4) ? 65536 : 0);
            sel = 4'(corner_hash(cl[0][k & 1], cl[1][(k >> 1) & 1], cl[2][(k >> 2) & 1],
                                 seed));
            ga = sel[3] ? dy : dx;
            gb = sel[3] ? dz : dy;
            g[k] = (sel[0] ? -ga : ga) + (sel[1] ? -gb : gb);
        end
        fu = fade_q16(fr[0]);
        fv = fade_q16(fr[1]);
        fw = fade_q16(fr[2]);
        n0 = mix(mix(g[0], g[1], fu), mix(g[2], g[3], fu), fv);
        n1 = mix(mix(g[4], g[5], fu), mix(g[6], g[7], fu), fv);
        return mix(n0, n1, fw);
    endfunction

    function automatic logic signed [17:0] predict_fbm(input logic signed [31:0] px,
                                                      input logic signed [31:0] py,
                                                      input logic signed [31:0] pz);
        int n;
        logic [63:0] pers, freq, amp;
        longint total, wtotal, res;
        n = (mdl_octaves > 8) ? 8 : mdl_octaves;
        pers = (mdl_persist > 17'd65536) ? 64'd65536 : 64'(mdl_persist);
        freq = 64'(mdl_scale);
        amp = 64'd65536;
        total = 0;
        wtotal = 0;
        if (n == 0)
        begin
            return '0;
        end
        for (int i = 0; i < n; i++)
        begin
            total += octave_value(px, py, pz, freq[31:0], mdl_seed + 32'(i)) * longint'(amp);
            wtotal += longint'(amp);
            amp = (amp * pers) >> 16;
            freq = (freq * 64'(mdl_lacun)) >> 8;
            if (freq > 64'hFFFF_FFFF)
            begin
                freq = 64'hFFFF_FFFF;
            end
        end
        res = total / wtotal;
        if (res > 131071)
        begin
            res = 131071;
        end
        if (res < -131072)
        begin
            res = -131072;
        end
        return res[17:0];
    endfunction

    // result checker and output stall generator
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_noise.size() == 0)
            begin
                $display("%0t unexpected word: expected none actual %0d", $time, noise_value);
                errors++;
            end
            else
            begin
                if (noise_value !== expected_noise[0])
                begin
                    $display("%0t noise_value mismatch: expected %0d actual %0d",
                             $time, expected_noise[0], noise_value);
                    errors++;
                end
                void'(expected_noise.pop_front());
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99, 0) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_word(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z);
        int gap;
        gap = 0;
        if ($urandom_range(99, 0) < tx_idle_pct)
        begin
            gap = $urandom_range(4, 1);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        do @(posedge clk); while (in_stall);
        expected_noise.push_back(predict_fbm(x, y, z));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_noise.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fbm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            fbm_pkg::REG_NOISE_SEED:   mdl_seed = value;
            fbm_pkg::REG_OCTAVE_COUNT: mdl_octaves = value[3:0];
            fbm_pkg::REG_PERSISTENCE:  mdl_persist = value[16:0];
            fbm_pkg::REG_LACUNARITY:   mdl_lacun = value[15:0];
            fbm_pkg::REG_BASE_SCALE:   mdl_scale = value[23:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] seed, input logic [3:0] oct,
                             input logic [16:0] pers, input logic [15:0] lac,
                             input logic [23:0] scale);
        wait_idle();
        write_reg(fbm_pkg::REG_NOISE_SEED, seed);
        write_reg(fbm_pkg::REG_OCTAVE_COUNT, 32'(oct));
        write_reg(fbm_pkg::REG_PERSISTENCE, 32'(pers));
        write_reg(fbm_pkg::REG_LACUNARITY, 32'(lac));
        write_reg(fbm_pkg::REG_BASE_SCALE, 32'(scale));
    endtask

    task automatic send_random_pos();
        logic signed [31:0] v[3];
        for (int a = 0; a < 3; a++)
        begin
            if ($urandom_range(3, 0) == 0)
            begin
                v[a] = $urandom;
            end
            else
            begin
                v[a] = $signed($urandom_range(32'h0100_0000, 0)) - 32'sh0080_0000;
            end
        end
        send_word(v[0], v[1], v[2]);
    endtask

    task automatic test_reset_defaults();
        send_word(0, 0, 0);
        send_word(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_word(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_word(32'sh0000_8000, 32'sh0001_4000, -32'sh0000_c000);
        send_word(32'shffff_ffff, 32'sh0000_0001, 32'sh0000_ffff);
        send_word(32'sh1234_5678, -32'sh0765_4321, 32'sh00ab_cdef);
    endtask

    task automatic test_register_extremes();
        write_all(32'h0, 4'd0, 17'd32768, 16'd512, 24'd65536);
        send_word(32'sh0003_8000, 32'sh0001_2000, 32'sh0005_7000);
        write_all(32'h7fff_ffff, 4'd8, 17'd65536, 16'd65535, 24'hff_ffff);
        send_word(32'sh0003_8000, -32'sh0001_2000, 32'sh0005_7000);
        send_word(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001);
        write_all(32'h8000_0000, 4'd15, 17'h1_ffff, 16'd256, 24'd65536);
        send_word(32'sh0003_8000, 32'sh0001_2000, -32'sh0005_7000);
        send_word(32'sh0000_7fff, 32'sh0000_4321, 32'sh0000_9999);
        write_all(32'hffff_ffff, 4'd3, 17'd0, 16'd0, 24'd65536);
        send_word(32'sh0003_8000, 32'sh0001_2000, 32'sh0005_7000);
        write_all(32'h1357_9bdf, 4'd5, 17'd40000, 16'd384, 24'd0);
        send_word(32'sh0003_8000, 32'sh0001_2000, 32'sh0005_7000);
        send_word(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
        write_all(32'h0000_0001, 4'd1, 17'd65535, 16'd1, 24'd1);
        send_word(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        wait_idle();
        write_reg(REG_UNUSED, 32'hffff_ffff);
        write_reg(fbm_pkg::REG_BASE_SCALE + 3'd1, 32'h0);
        send_word(32'sh0002_4000, 32'sh0006_1000, 32'sh0000_3000);
    endtask

    task automatic random_settings();
        logic [3:0] oct;
        oct = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8, 0));
        write_all($urandom, oct, 17'($urandom_range(131071, 0)),
                  16'($urandom_range(65535, 0)), 24'($urandom_range(24'hff_ffff, 0)));
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                random_settings();
            end
            send_random_pos();
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_all($urandom, 4'd8, 17'd50000, 16'd600, 24'd70000);
        hold_cycles = 400;
        for (int i = 0; i < 60; i++)
        begin
            send_random_pos();
        end
        wait_idle();
    endtask

    initial
    begin
        mdl_seed = 32'h0;
        mdl_octaves = 4'd4;
        mdl_persist = 17'd32768;
        mdl_lacun = 16'd512;
        mdl_scale = 24'd65536;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_random(14, 54, 580);
        test_random(54, 14, 580);
        test_random(0, 0, 590);
        test_backpressure();
        wait_idle();
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

>>> filelist.f
sv/fbm_pkg.sv
sv/fbm_gradient_noise_3d.sv
sim/testbench.sv
